/* rtl/core/psc_pkg.sv */
// Shared types and constants for the paired sample correlation block.
// Holds the controller opcodes, the command/status structs and the datapath widths.
// No dependencies.
package psc_pkg;

	localparam int WORD_W   = 64;   // modular width of the set arithmetic
	localparam int PROD_W   = 192;  // serial multiplier accumulator
	localparam int MB_W     = 128;  // serial multiplier multiplicand
	localparam int DVD_W    = 80;   // dividend {num, 16 fraction zeros}
	localparam int FRAC_W   = 16;
	localparam int K_W      = 17;   // correlation magnitude, 0..65536
	localparam int KIDX_W   = 5;    // index of a correlation bit
	localparam int KSQ_W    = 34;   // square of a trial correlation
	localparam int RHS_W    = 160;  // c*c shifted by 32
	localparam int SAMPLE_W = 16;
	localparam int TDATA_IN_W  = 32;
	localparam int TDATA_OUT_W = 248;

	localparam logic [K_W-1:0]    K_ONE   = 17'h10000;  // +1.0 in Q1.16
	localparam logic [KIDX_W-1:0] K_TOP   = 5'd16;

	// Controller steps; each names one unit operation and its destination.
	typedef enum logic [4:0] {
		OP_NSXX, OP_SX2, OP_NSYY, OP_SY2, OP_NSXY, OP_SXSY, OP_DEN,
		OP_MX, OP_MY, OP_VX, OP_VY, OP_CV,
		OP_P, OP_CM2, OP_CAND, OP_TRY, OP_LOAD
	} op_t;

	typedef struct packed {
		logic              acc;      // accumulate the accepted item
		logic              start;    // start the unit selected by op
		op_t               op;
		logic [KIDX_W-1:0] bit_idx;  // correlation bit under trial
		logic              load;     // copy results out, clear sums
	} cmd_t;

	typedef struct packed {
		logic done;       // running unit finished, result captured
		logic zero_var;
		logic out_full;
	} stat_t;

endpackage

/* rtl/core/psc_mul.sv */
// Shift-and-add multiplier, one multiplier bit per cycle, early exit on zero.
// Depends on psc_pkg for widths.
module psc_mul import psc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [WORD_W-1:0] a,
	input  logic [MB_W-1:0]   b,
	output logic              busy,
	output logic              done,
	output logic [PROD_W-1:0] prod
);

	logic              busy_q;
	logic [WORD_W-1:0] a_q;
	logic [PROD_W-1:0] b_q;
	logic [PROD_W-1:0] acc_q;

	assign busy = busy_q;
	assign done = busy_q && (a_q == '0);
	assign prod = acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
		end else if (done) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			b_q   <= PROD_W'(b);
			acc_q <= '0;
		end else if (busy_q && (a_q != '0)) begin
			if (a_q[0]) begin
				acc_q <= acc_q + b_q;
			end
			a_q <= a_q >> 1;
			b_q <= b_q << 1;
		end
	end

endmodule

/* rtl/core/psc_div.sv */
// Restoring divider: floor({num,16'b0}/den), one quotient bit per cycle.
// Depends on psc_pkg for widths.
module psc_div import psc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [WORD_W-1:0] num,
	input  logic [WORD_W-1:0] den,
	output logic              busy,
	output logic              done,
	output logic [WORD_W-1:0] quot,
	output logic              inexact
);

	localparam int CNT_W = $clog2(DVD_W + 1);

	logic              busy_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [DVD_W-1:0]  dq_q;
	logic [WORD_W:0]   rem_q;
	logic [WORD_W-1:0] den_q;
	logic [WORD_W:0]   trial;
	logic              ge;

	assign trial   = {rem_q[WORD_W-1:0], dq_q[DVD_W-1]};
	assign ge      = trial >= {1'b0, den_q};
	assign busy    = busy_q;
	assign done    = busy_q && (cnt_q == '0);
	assign quot    = dq_q[WORD_W-1:0];
	assign inexact = rem_q != '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(DVD_W);
		end else if (done) begin
			busy_q <= 1'b0;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dq_q  <= {num, {FRAC_W{1'b0}}};
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q && (cnt_q != '0)) begin
			rem_q <= ge ? (trial - {1'b0, den_q}) : trial;
			dq_q  <= {dq_q[DVD_W-2:0], ge};
		end
	end

endmodule

/* rtl/core/psc_dp.sv */
// Datapath: set accumulators, work registers, multiplier and divider, result register.
// Depends on psc_pkg, psc_mul and psc_div.
module psc_dp import psc_pkg::*; #(
	parameter int MAX_PAIRS = 65536
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  cmd_t                   cmd,
	output stat_t                  stat,
	input  logic [TDATA_IN_W-1:0]  s_tdata,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [TDATA_OUT_W-1:0] m_tdata
);

	localparam int CW  = $clog2(MAX_PAIRS + 1);
	localparam int SXW = SAMPLE_W + CW;
	localparam int SQW = 2 * SAMPLE_W - 2 + CW;
	localparam int SPW = 2 * SAMPLE_W - 1 + CW;

	function automatic logic [WORD_W-1:0] mag(input logic [WORD_W-1:0] v);
		return v[WORD_W-1] ? (~v + 1'b1) : v;
	endfunction

	// floor toward minus infinity for a negative dividend
	function automatic logic [WORD_W-1:0] sfix(input logic [WORD_W-1:0] q,
		input logic inx, input logic neg);
		logic [WORD_W-1:0] t;
		t = q + WORD_W'(inx);
		return neg ? (~t + 1'b1) : q;
	endfunction

	// accumulators
	logic [CW-1:0]         n_q;
	logic signed [SXW-1:0] sx_q, sy_q;
	logic [SQW-1:0]        sxx_q, syy_q;
	logic signed [SPW-1:0] sxy_q;
	logic                  ovf_q;

	// work registers
	logic [WORD_W-1:0] t64_q, nx_q, ny_q, c_q, den_q;
	logic [MB_W-1:0]   p_q;
	logic [RHS_W-1:0]  rhs_q;
	logic [KSQ_W-1:0]  ksq_q;
	logic [K_W-1:0]    k_q, cand_q;
	logic [31:0]       mx_q, my_q;
	logic [46:0]       vx_q, vy_q;
	logic [47:0]       cv_q;

	// result register
	logic        m_valid_q;
	logic [16:0] o_cnt_q;
	logic [31:0] o_mx_q, o_my_q;
	logic [46:0] o_vx_q, o_vy_q;
	logic [47:0] o_cv_q;
	logic [17:0] o_corr_q;
	logic        o_zv_q, o_ovf_q;

	logic signed [SAMPLE_W-1:0] x, y;
	logic signed [31:0]         xx, yy, xy;
	logic [WORD_W-1:0]          n64, sx64, sy64, sxx64, syy64, sxy64;
	logic [WORD_W-1:0]          mul_a, div_num, div_den, sfixed;
	logic [MB_W-1:0]            mul_b;
	logic [PROD_W-1:0]          prod;
	logic [WORD_W-1:0]          quot;
	logic                       is_div, div_neg, inexact, zv;
	logic                       mul_busy, mul_done, div_busy, div_done;
	logic [K_W-1:0]             cand;
	logic [17:0]                corr;

	assign x     = s_tdata[SAMPLE_W-1:0];
	assign y     = s_tdata[2*SAMPLE_W-1:SAMPLE_W];
	assign xx    = x * x;
	assign yy    = y * y;
	assign xy    = x * y;
	assign n64   = WORD_W'(n_q);
	assign sx64  = WORD_W'(sx_q);
	assign sy64  = WORD_W'(sy_q);
	assign sxx64 = WORD_W'(sxx_q);
	assign syy64 = WORD_W'(syy_q);
	assign sxy64 = WORD_W'(sxy_q);
	assign zv    = (nx_q == '0) || (ny_q == '0);
	assign cand  = k_q | (K_W'(1) << cmd.bit_idx);
	assign is_div = (cmd.op == OP_MX) || (cmd.op == OP_MY) || (cmd.op == OP_VX) ||
		(cmd.op == OP_VY) || (cmd.op == OP_CV);

	always_comb begin
		mul_a   = '0;
		mul_b   = '0;
		div_num = '0;
		div_den = den_q;
		div_neg = 1'b0;
		case (cmd.op)
			OP_NSXX: begin mul_a = n64;        mul_b = MB_W'(sxx64);     end
			OP_SX2:  begin mul_a = mag(sx64);  mul_b = MB_W'(mag(sx64)); end
			OP_NSYY: begin mul_a = n64;        mul_b = MB_W'(syy64);     end
			OP_SY2:  begin mul_a = mag(sy64);  mul_b = MB_W'(mag(sy64)); end
			OP_NSXY: begin mul_a = n64;        mul_b = MB_W'(sxy64);     end
			OP_SXSY: begin mul_a = sx64;       mul_b = MB_W'(sy64);      end
			OP_DEN:  begin mul_a = n64;        mul_b = MB_W'(n64);       end
			OP_P:    begin mul_a = nx_q;       mul_b = MB_W'(ny_q);      end
			OP_CM2:  begin mul_a = mag(c_q);   mul_b = MB_W'(mag(c_q));  end
			OP_CAND: begin mul_a = WORD_W'(cand); mul_b = MB_W'(cand);   end
			OP_TRY:  begin mul_a = WORD_W'(ksq_q); mul_b = p_q;          end
			OP_MX:   begin div_num = mag(sx64); div_den = n64; div_neg = sx64[WORD_W-1]; end
			OP_MY:   begin div_num = mag(sy64); div_den = n64; div_neg = sy64[WORD_W-1]; end
			OP_VX:   begin div_num = nx_q; end
			OP_VY:   begin div_num = ny_q; end
			OP_CV:   begin div_num = mag(c_q); div_neg = c_q[WORD_W-1]; end
			default: begin end
		endcase
	end

	assign sfixed = sfix(quot, inexact, div_neg);

	psc_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.start && !is_div),
		.a      (mul_a),
		.b      (mul_b),
		.busy   (mul_busy),
		.done   (mul_done),
		.prod   (prod)
	);

	psc_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.start && is_div),
		.num     (div_num),
		.den     (div_den),
		.busy    (div_busy),
		.done    (div_done),
		.quot    (quot),
		.inexact (inexact)
	);

	// accumulators: clear on load; else add the item, or drop it once the count is full
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q   <= '0;
			sx_q  <= '0;
			sy_q  <= '0;
			sxx_q <= '0;
			syy_q <= '0;
			sxy_q <= '0;
			ovf_q <= 1'b0;
		end else if (cmd.load) begin
			n_q   <= '0;
			sx_q  <= '0;
			sy_q  <= '0;
			sxx_q <= '0;
			syy_q <= '0;
			sxy_q <= '0;
			ovf_q <= 1'b0;
		end else if (cmd.acc) begin
			if (n_q == CW'(MAX_PAIRS)) begin
				ovf_q <= 1'b1;
			end else begin
				n_q   <= n_q + 1'b1;
				sx_q  <= sx_q + SXW'(x);
				sy_q  <= sy_q + SXW'(y);
				sxx_q <= sxx_q + SQW'(xx[2*SAMPLE_W-2:0]);
				syy_q <= syy_q + SQW'(yy[2*SAMPLE_W-2:0]);
				sxy_q <= sxy_q + SPW'(xy);
			end
		end
	end

	// capture unit results into the register the current step names; clear k and latch cand at step start
	always_ff @(posedge clk) begin
		if (cmd.start && (cmd.op == OP_P)) begin
			k_q <= '0;
		end
		if (cmd.start && (cmd.op == OP_CAND)) begin
			cand_q <= cand;
		end
		if (mul_done) begin
			case (cmd.op)
				OP_NSXX, OP_NSYY, OP_NSXY: t64_q <= prod[WORD_W-1:0];
				OP_SX2:  nx_q  <= (t64_q >= prod[WORD_W-1:0]) ? t64_q - prod[WORD_W-1:0] : '0;
				OP_SY2:  ny_q  <= (t64_q >= prod[WORD_W-1:0]) ? t64_q - prod[WORD_W-1:0] : '0;
				OP_SXSY: c_q   <= t64_q - prod[WORD_W-1:0];
				OP_DEN:  den_q <= prod[WORD_W-1:0];
				OP_P:    p_q   <= prod[MB_W-1:0];
				OP_CM2:  rhs_q <= {prod[MB_W-1:0], 32'd0};
				OP_CAND: ksq_q <= prod[KSQ_W-1:0];
				OP_TRY: begin
					if ((prod <= PROD_W'(rhs_q)) && (cand_q <= K_ONE)) begin
						k_q <= cand_q;
					end
				end
				default: begin end
			endcase
		end
		if (div_done) begin
			case (cmd.op)
				OP_MX:   mx_q <= sfixed[31:0];
				OP_MY:   my_q <= sfixed[31:0];
				OP_VX:   vx_q <= quot[46:0];
				OP_VY:   vy_q <= quot[46:0];
				OP_CV:   cv_q <= sfixed[47:0];
				default: begin end
			endcase
		end
	end

	assign corr = zv ? '0 : (c_q[WORD_W-1] ? (~{1'b0, k_q} + 1'b1) : {1'b0, k_q});

	// result register: hold until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (cmd.load) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			o_cnt_q  <= n64[16:0];
			o_mx_q   <= mx_q;
			o_my_q   <= my_q;
			o_vx_q   <= vx_q;
			o_vy_q   <= vy_q;
			o_cv_q   <= cv_q;
			o_corr_q <= corr;
			o_zv_q   <= zv;
			o_ovf_q  <= ovf_q;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {5'd0, o_ovf_q, o_zv_q, o_corr_q, o_cv_q, o_vy_q, o_vx_q,
		o_my_q, o_mx_q, o_cnt_q};

	assign stat.done     = mul_done || div_done;
	assign stat.zero_var = zv;
	assign stat.out_full = m_valid_q;

	assert property (@(posedge clk) disable iff (!arst_n) !(mul_busy && div_busy))
		else $error("multiplier and divider busy together");
	assert property (@(posedge clk) disable iff (!arst_n) cmd.load |-> !m_valid_q)
		else $error("result register overwritten before it was taken");
	assert property (@(posedge clk) disable iff (!arst_n) n_q <= CW'(MAX_PAIRS))
		else $error("pair count beyond its limit");

endmodule

/* rtl/core/psc_ctrl.sv */
// Controller: walks the end-of-set sequence of multiplies, divides and correlation trials.
// Depends on psc_pkg.
module psc_ctrl import psc_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  s_tvalid,
	output logic  s_tready,
	input  logic  s_tlast,
	output cmd_t  cmd,
	input  stat_t stat
);

	typedef enum logic [2:0] {ST_ACC, ST_ISSUE, ST_WAIT, ST_OUT, ST_DONE} state_t;

	state_t            state_q;
	op_t               step_q, nxt_step;
	logic [KIDX_W-1:0] bit_q, nxt_bit;
	logic              s_tready_q, start_q, load_q;
	logic              acc;

	assign acc = s_tvalid && s_tready_q;

	always_comb begin
		nxt_step = step_q;
		nxt_bit  = bit_q;
		case (step_q)
			OP_CV:   nxt_step = stat.zero_var ? OP_LOAD : OP_P;
			OP_CM2: begin
				nxt_step = OP_CAND;
				nxt_bit  = K_TOP;
			end
			OP_CAND: nxt_step = OP_TRY;
			OP_TRY: begin
				if (bit_q == '0) begin
					nxt_step = OP_LOAD;
				end else begin
					nxt_step = OP_CAND;
					nxt_bit  = bit_q - 1'b1;
				end
			end
			OP_LOAD: nxt_step = OP_LOAD;
			default: nxt_step = op_t'(step_q + 1'b1);
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_ACC;
			step_q     <= OP_NSXX;
			bit_q      <= '0;
			s_tready_q <= 1'b1;
			start_q    <= 1'b0;
			load_q     <= 1'b0;
		end else begin
			case (state_q)
				ST_ACC: begin
					if (acc && s_tlast) begin
						s_tready_q <= 1'b0;
						step_q     <= OP_NSXX;
						state_q    <= ST_ISSUE;
					end
				end
				ST_ISSUE: begin
					start_q <= 1'b1;
					state_q <= ST_WAIT;
				end
				ST_WAIT: begin
					start_q <= 1'b0;
					if (stat.done) begin
						step_q  <= nxt_step;
						bit_q   <= nxt_bit;
						state_q <= (nxt_step == OP_LOAD) ? ST_OUT : ST_ISSUE;
					end
				end
				ST_OUT: begin
					if (!stat.out_full) begin
						load_q  <= 1'b1;
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					load_q     <= 1'b0;
					s_tready_q <= 1'b1;
					state_q    <= ST_ACC;
				end
				default: state_q <= ST_ACC;
			endcase
		end
	end

	assign s_tready    = s_tready_q;
	assign cmd.acc     = acc;
	assign cmd.start   = start_q;
	assign cmd.op      = step_q;
	assign cmd.bit_idx = bit_q;
	assign cmd.load    = load_q;

	assert property (@(posedge clk) disable iff (!arst_n) s_tready_q |-> (state_q == ST_ACC))
		else $error("input ready outside accumulation");
	assert property (@(posedge clk) disable iff (!arst_n) start_q |=> !start_q)
		else $error("unit start longer than one cycle");
	assert property (@(posedge clk) disable iff (!arst_n) load_q |-> !start_q && !s_tready_q)
		else $error("load overlaps a unit start or an input item");

endmodule

/* rtl/core/paired_sample_correlation_top.sv */
// Paired sample correlation: count, means, variances, covariance and Pearson correlation.
// Throughput: one item per cycle while a set accumulates (one 16x16 product per product sum).
// The last item of a set holds the input, plus any wait for the previous result, while the
// controller runs up to nine serial multiplies, five 80-step divisions and up to 17 correlation
// trial rounds of two multiplies, on one shift-add unit and one divider.
// Reset (arst_n low, asynchronous) clears the sums, the count, the FSM and tvalid.
module paired_sample_correlation_top import psc_pkg::*; #(
	parameter int MAX_PAIRS = 65536
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// input items
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [TDATA_IN_W-1:0]  s_tdata,   // [15:0] sample_x, [31:16] sample_y
	input  logic                   s_tlast,   // last_pair
	// result items
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [TDATA_OUT_W-1:0] m_tdata    // [16:0] pair_count, [48:17] mean_x,
	                                          // [80:49] mean_y, [127:81] variance_x,
	                                          // [174:128] variance_y, [222:175] covariance,
	                                          // [240:223] correlation, [241] zero_variance,
	                                          // [242] count_overflow, rest zero
);

	// The controller only sequences; every number lives in the datapath.
	cmd_t  cmd;
	stat_t stat;

	// Accumulate each accepted item; on the last one stop taking items,
	// run the end-of-set sequence, then park the result in the output
	// register and clear the sums so a new set can start while it waits.
	psc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tlast  (s_tlast),
		.cmd      (cmd),
		.stat     (stat)
	);

	// Sums, products, quotients and the correlation bit search.
	psc_dp #(
		.MAX_PAIRS (MAX_PAIRS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.stat     (stat),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

/* verif/paired_sample_correlation_checker.sv */
// Checker for the paired sample correlation block: watches both streams, keeps its own
// running sums and set statistics, and compares each result item field by field.
// Depends on psc_pkg for the stream widths.
module paired_sample_correlation_checker import psc_pkg::*; #(
	parameter int MAX_PAIRS = 65536
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	input  logic                   s_tready,
	input  logic [TDATA_IN_W-1:0]  s_tdata,
	input  logic                   s_tlast,
	input  logic                   m_tvalid,
	input  logic                   m_tready,
	input  logic [TDATA_OUT_W-1:0] m_tdata,
	output int                     errors,
	output int                     pending
);

	// highest field first, so pair_count sits in the lowest bits
	typedef struct packed {
		logic        count_overflow;
		logic        zero_variance;
		logic [17:0] correlation;
		logic [47:0] covariance;
		logic [46:0] variance_y;
		logic [46:0] variance_x;
		logic [31:0] mean_y;
		logic [31:0] mean_x;
		logic [16:0] pair_count;
	} set_stats_t;

	set_stats_t stats_due[$];

	// Running sums, modulo 2^64 like the block's set arithmetic.
	logic [63:0] n_pairs, sx, sy, sxx, syy, sxy;
	logic        full_seen;

	// floor(65536*num/den), unsigned; flag set when a remainder is left
	function automatic logic [63:0] q16_quot(logic [63:0] num, logic [63:0] den,
			output logic inexact);
		logic [63:0] q, r, rs;
		q = num / den;
		r = num % den;
		rs = r << 16;
		inexact = (rs % den) != 0;
		return (q << 16) + rs / den;
	endfunction

	// signed floor(65536*s/den), s two's complement
	function automatic logic [63:0] q16_quot_signed(logic [63:0] s, logic [63:0] den);
		logic [63:0] q, mag;
		logic        inexact;
		mag = s[63] ? -s : s;
		q = q16_quot(mag, den, inexact);
		return s[63] ? -(q + {63'b0, inexact}) : q;
	endfunction

	function automatic logic [63:0] spread_num(logic [63:0] n, logic [63:0] sq,
			logic [63:0] s);
		logic [63:0] a, m, b;
		a = n * sq;
		m = s[63] ? -s : s;
		b = m * m;
		return (a >= b) ? a - b : 64'd0;
	endfunction

	// Largest k in 0..65536 with k*sqrt(nx*ny) <= 65536*|c|, signed like c.
	function automatic logic [17:0] corr_q1_16(logic [63:0] nx, logic [63:0] ny,
			logic [63:0] c);
		logic [191:0] p, rhs, lhs;
		logic [63:0]  cm, lo, hi, mid;
		p = {128'b0, nx} * {128'b0, ny};
		cm = c[63] ? -c : c;
		rhs = ({128'b0, cm} * {128'b0, cm}) << 32;
		lo = 0;
		hi = 65536;
		while (lo < hi) begin
			mid = (lo + hi + 1) / 2;
			lhs = {128'b0, mid * mid} * p;
			if (lhs <= rhs)
				lo = mid;
			else
				hi = mid - 1;
		end
		return c[63] ? 18'(-lo) : 18'(lo);
	endfunction

	function automatic set_stats_t close_set();
		set_stats_t  r;
		logic [63:0] den, nx, ny, c;
		logic        dummy;
		den = n_pairs * n_pairs;
		nx = spread_num(n_pairs, sxx, sx);
		ny = spread_num(n_pairs, syy, sy);
		c = n_pairs * sxy - sx * sy;
		r.pair_count     = n_pairs[16:0];
		r.mean_x         = 32'(q16_quot_signed(sx, n_pairs));
		r.mean_y         = 32'(q16_quot_signed(sy, n_pairs));
		r.variance_x     = 47'(q16_quot(nx, den, dummy));
		r.variance_y     = 47'(q16_quot(ny, den, dummy));
		r.covariance     = 48'(q16_quot_signed(c, den));
		r.zero_variance  = (nx == 0) || (ny == 0);
		r.correlation    = r.zero_variance ? 18'd0 : corr_q1_16(nx, ny, c);
		r.count_overflow = full_seen;
		return r;
	endfunction

	task automatic flag(string field, logic [63:0] want, logic [63:0] got);
		$display("%0t: mismatch in %s: expected %0h, actual %0h", $time, field, want, got);
		errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		set_stats_t  want, got;
		logic [63:0] x, y;
		if (!arst_n) begin
			n_pairs = 0; sx = 0; sy = 0; sxx = 0; syy = 0; sxy = 0;
			full_seen = 0;
			errors = 0;
			pending <= 0;
		end else begin
			if (s_tvalid && s_tready) begin
				x = {{48{s_tdata[15]}}, s_tdata[15:0]};
				y = {{48{s_tdata[31]}}, s_tdata[31:16]};
				// a full count drops the pair from every sum
				if (n_pairs >= MAX_PAIRS) begin
					full_seen = 1;
				end else begin
					n_pairs = n_pairs + 1;
					sx = sx + x;
					sy = sy + y;
					sxx = sxx + x * x;
					syy = syy + y * y;
					sxy = sxy + x * y;
				end
				if (s_tlast) begin
					stats_due.insert(stats_due.size(), close_set());
					n_pairs = 0; sx = 0; sy = 0; sxx = 0; syy = 0; sxy = 0;
					full_seen = 0;
				end
			end
			if (m_tvalid && m_tready) begin
				got = m_tdata[$bits(set_stats_t)-1:0];
				if (stats_due.size() == 0) begin
					$display("%0t: result item with none expected, actual %0h",
						$time, m_tdata);
					errors++;
				end else begin
					want = stats_due.pop_front();
					if (want.pair_count != got.pair_count)
						flag("pair_count", want.pair_count, got.pair_count);
					if (want.mean_x != got.mean_x)
						flag("mean_x", want.mean_x, got.mean_x);
					if (want.mean_y != got.mean_y)
						flag("mean_y", want.mean_y, got.mean_y);
					if (want.variance_x != got.variance_x)
						flag("variance_x", want.variance_x, got.variance_x);
					if (want.variance_y != got.variance_y)
						flag("variance_y", want.variance_y, got.variance_y);
					if (want.covariance != got.covariance)
						flag("covariance", want.covariance, got.covariance);
					if (want.correlation != got.correlation)
						flag("correlation", want.correlation, got.correlation);
					if (want.zero_variance != got.zero_variance)
						flag("zero_variance", want.zero_variance, got.zero_variance);
					if (want.count_overflow != got.count_overflow)
						flag("count_overflow", want.count_overflow, got.count_overflow);
				end
			end
			pending <= stats_due.size();
		end
	end

endmodule

/* verif/paired_sample_correlation_top_tb.sv */
// Testbench top for the paired sample correlation block: clock, reset, sample sets
// with bursty input and patterned result stalls, and the final verdict.
// Depends on psc_pkg, paired_sample_correlation_top and paired_sample_correlation_checker.
module paired_sample_correlation_top_tb;
	import psc_pkg::*;

	localparam int  MAX_PAIRS   = 65536;
	localparam int  PAIR_TARGET = 1450;
	localparam longint CYCLE_LIMIT = 10000000;

	logic                   clk = 0;
	logic                   arst_n = 0;
	logic                   s_tvalid = 0;
	logic                   s_tready;
	logic [TDATA_IN_W-1:0]  s_tdata = '0;
	logic                   s_tlast = 0;
	logic                   m_tvalid;
	logic                   m_tready = 0;
	logic [TDATA_OUT_W-1:0] m_tdata;
	int                     errors;
	int                     pending;
	longint                 cycles = 0;
	int                     burst_left = 0;
	int                     pairs_sent = 0;

	paired_sample_correlation_top #(.MAX_PAIRS(MAX_PAIRS)) DUT (
		.clk, .arst_n,
		.s_tvalid, .s_tready, .s_tdata, .s_tlast,
		.m_tvalid, .m_tready, .m_tdata
	);

	paired_sample_correlation_checker #(.MAX_PAIRS(MAX_PAIRS)) checker_i (
		.clk, .arst_n,
		.s_tvalid, .s_tready, .s_tdata, .s_tlast,
		.m_tvalid, .m_tready, .m_tdata,
		.errors, .pending
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// Watchdog: fail and end the run once it outlasts CYCLE_LIMIT, as when the block stops making progress.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// Receiver stall pattern: rotate through always ready, coin flip, mostly
	// stalled, and long stall stretches.
	always @(posedge clk) begin
		case ((cycles / 700) % 4)
			0: m_tready <= 1'b1;
			1: m_tready <= $urandom_range(0, 1);
			2: m_tready <= ($urandom_range(0, 3) == 0);
			default: m_tready <= ((cycles % 96) < 10);
		endcase
	end

	// Drive one pair; open a new burst with a random gap when the old one runs out.
	task automatic send_pair(logic [15:0] x, logic [15:0] y, logic last);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
			if (gap != 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {y, x};
		s_tlast  <= last;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		burst_left--;
		pairs_sent++;
	endtask

	// Hold the input low until every pending result has arrived.
	task automatic drain();
		s_tvalid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	// Pick a sample for a random set according to its flavor.
	function automatic logic [15:0] pick(int flavor, logic [15:0] base);
		case (flavor)
			0: return 16'($urandom);
			1: return 16'($signed(base) + $signed(16'($urandom_range(0, 6)) - 16'sd3));
			2: return base;
			3: return ($urandom_range(0, 1) != 0) ? 16'h8000 : 16'h7fff;
			default: return 16'($signed(16'($urandom_range(0, 40))) - 16'sd20);
		endcase
	endfunction

	initial begin
		int          len, fx, fy;
		logic [15:0] x, y, bx, by;
		logic        drained_once;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Single pair of extremes: zero variance on both sides.
		send_pair(16'h8000, 16'h7fff, 1'b1);
		// Two opposite extremes: correlation of minus one.
		send_pair(16'h8000, 16'h7fff, 1'b0);
		send_pair(16'h7fff, 16'h8000, 1'b1);
		// Identical series: correlation of plus one.
		send_pair(16'h8000, 16'h8000, 1'b0);
		send_pair(16'h7fff, 16'h7fff, 1'b0);
		send_pair(16'h8000, 16'h8000, 1'b1);
		// Constant x against varying y: zero variance on one side.
		send_pair(16'h0005, 16'h0001, 1'b0);
		send_pair(16'h0005, 16'hffff, 1'b0);
		send_pair(16'h0005, 16'h1234, 1'b1);
		// All zero, then a set mixing minus one and plus one.
		send_pair(16'h0000, 16'h0000, 1'b0);
		send_pair(16'h0000, 16'h0000, 1'b1);
		send_pair(16'hffff, 16'hffff, 1'b0);
		send_pair(16'hffff, 16'h0001, 1'b0);
		send_pair(16'h0001, 16'hffff, 1'b1);
		// Negative exact mean for x, positive mean with a remainder for y.
		send_pair(16'hffff, 16'h0003, 1'b0);
		send_pair(16'hfffe, 16'h0000, 1'b0);
		send_pair(16'h0000, 16'h0001, 1'b1);
		drain();

		// Random sets: mostly short, a few longer, with varied sample flavors.
		drained_once = 0;
		while (pairs_sent < PAIR_TARGET) begin
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 200)
				: $urandom_range(1, 16);
			fx = $urandom_range(0, 4);
			fy = $urandom_range(0, 4);
			bx = 16'($urandom);
			by = 16'($urandom);
			for (int i = 0; i < len; i++) begin
				x = pick(fx, bx);
				// For y flavor 1 with a non-constant x flavor, y is x or -x, the sign picked per pair.
				y = (fy == 1 && fx != 2) ? (($urandom_range(0, 1) != 0) ? x : -x)
					: pick(fy, by);
				send_pair(x, y, i == len - 1);
			end
			if (!drained_once && pairs_sent > PAIR_TARGET / 2) begin
				drain();
				drained_once = 1;
			end
		end

		drain();
		repeat (3000) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
